// ----- hdl/fca_pkg.sv -----
`default_nettype none
package fca_pkg;
    localparam int NUM_BLOCKS = 1024;
    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int ENTRY_W = 11;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [ENTRY_W-1:0] END_MARK = 11'h7FF;

    localparam logic [1:0] ACT_GROW = 2'd0;
    localparam logic [1:0] ACT_SHRINK = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_COUNT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FEW_FREE = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] start_block;
        logic [9:0] amount;
    } req_t;

    typedef struct packed {
        logic [9:0] new_start;
        logic [10:0] found_block;
        logic [10:0] chain_length;
        logic [9:0] blocks_added;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_HOOK,
        S_WALK_CHK,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_FINISH,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- hdl/fca_ram.sv -----
`default_nettype none
module fca_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/fat_chain_allocator_top.sv -----
`default_nettype none
// Cluster-chain allocator over a 1024-entry file allocation table held in one
// synchronous RAM. After reset a clearing pass writes every entry (entry 0
// gets the end marker); no request is taken until it ends, though
// configuration writes are accepted throughout. Each request transaction
// first walks the chain from start_block (skipped if start_block is 0 or not
// below the managed entry count), reading each link in S_WALK_RD and checking
// it in S_WALK_CHK. Grow then scans the table from entry 0 for free entries,
// reading and checking each entry in turn and linking each block found to the
// previous one as it goes; it then writes the end marker and, in S_HOOK, hooks
// the fresh run onto the chain's tail if the chain was not empty. Shrink walks
// the chain a second time to the cut point and frees the tail, and then marks
// the new last block unless the whole chain was freed. The RAM port is the
// bound on rate. The result is held in an output register until its
// transaction completes; one request is in work at a time.
module fat_chain_allocator_top (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [10:0] cfg_data,
    input wire logic in_valid,
    output logic in_ready,
    input wire fca_pkg::req_t in_data,
    output logic out_valid,
    input wire logic out_ready,
    output fca_pkg::rsp_t out_data
);
    import fca_pkg::*;

    state_t state_reg, state_next;
    logic [10:0] biu_reg;
    req_t req_reg, req_next;
    rsp_t rsp_reg, rsp_next;
    logic [IDX_W-1:0] cur_reg, cur_next;       // current block or scan index
    logic [CNT_W-1:0] len_reg, len_next;       // walked chain length
    logic [IDX_W-1:0] tail_reg, tail_next;     // last chain block
    logic [IDX_W-1:0] prev_reg, prev_next;     // last freshly linked block
    logic [IDX_W-1:0] first_reg, first_next;   // first fresh block
    logic [CNT_W-1:0] cnt_reg, cnt_next;       // added count or step count
    logic [ENTRY_W-1:0] found_reg, found_next;

    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [CNT_W-1:0] n_eff;

    fca_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BLOCKS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Managed entries: min(blocks_in_use, NUM_BLOCKS).
    assign n_eff = (biu_reg > 11'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_reg);

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            biu_reg <= 11'd1024;
            cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            if (cfg_valid && cfg_ready)
            begin
                biu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        len_reg <= len_next;
        tail_reg <= tail_next;
        prev_reg <= prev_next;
        first_reg <= first_next;
        cnt_reg <= cnt_next;
        found_reg <= found_next;
    end

    always_comb
    begin
        logic [CNT_W-1:0] cut;
        state_next = state_reg;
        req_next = req_reg;
        rsp_next = rsp_reg;
        cur_next = cur_reg;
        len_next = len_reg;
        tail_next = tail_reg;
        prev_next = prev_reg;
        first_next = first_reg;
        cnt_next = cnt_reg;
        found_next = found_reg;
        we = 1'b0;
        waddr = cur_reg;
        wdata = '0;
        raddr = cur_reg;
        cut = len_reg - CNT_W'(req_reg.amount);
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wdata = (cur_reg == '0) ? END_MARK : '0;
                cur_next = cur_reg + 1'b1;
                if (cur_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    len_next = '0;
                    found_next = END_MARK;
                    cur_next = in_data.start_block;
                    if (in_data.start_block == '0 || CNT_W'(in_data.start_block) >= n_eff)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                // Block cur_reg is in the chain; read its link.
                if (len_reg == CNT_W'(req_reg.amount))
                begin
                    found_next = {1'b0, cur_reg};
                end
                tail_next = cur_reg;
                len_next = len_reg + 1'b1;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (len_reg >= n_eff || rdata == '0 || rdata == END_MARK
                    || rdata >= ENTRY_W'(n_eff))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cur_next = rdata[IDX_W-1:0];
                    state_next = S_WALK_RD;
                end
            end
            S_DECIDE:
            begin
                rsp_next.new_start = req_reg.start_block;
                rsp_next.found_block = '0;
                rsp_next.chain_length = len_reg;
                rsp_next.blocks_added = '0;
                rsp_next.status = ST_OK;
                case (req_reg.action)
                    ACT_GROW:
                    begin
                        cnt_next = '0;
                        cur_next = '0;
                        if (req_reg.amount == '0)
                        begin
                            rsp_next.status = ST_FEW_FREE;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    ACT_SHRINK:
                    begin
                        if (len_reg < CNT_W'(req_reg.amount))
                        begin
                            rsp_next.status = ST_TOO_SHORT;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            rsp_next.chain_length = cut;
                            if (cut == '0)
                            begin
                                rsp_next.new_start = '0;
                            end
                            cnt_next = '0;
                            cur_next = req_reg.start_block;
                            if (req_reg.amount == '0)
                            begin
                                // Nothing is freed, but the last block still
                                // gets the end marker.
                                state_next = (cut == '0) ? S_OUT : S_HOOK;
                            end
                            else
                            begin
                                state_next = S_FREE_RD;
                            end
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        rsp_next.found_block = found_reg;
                        if (CNT_W'(req_reg.amount) >= len_reg)
                        begin
                            rsp_next.status = ST_TOO_SHORT;
                        end
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (rdata == '0)
                begin
                    // Free entry: link it behind the previous fresh block.
                    if (cnt_reg == '0)
                    begin
                        first_next = cur_reg;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = prev_reg;
                        wdata = {1'b0, cur_reg};
                    end
                    prev_next = cur_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
                if ((rdata == '0 && cnt_reg + 1'b1 == CNT_W'(req_reg.amount))
                    || CNT_W'(cur_reg) + 1'b1 >= n_eff)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_FINISH:
            begin
                // If any block was found, mark the new tail; unless the chain was empty, the
                // fresh run is hooked onto the chain in the following cycle.
                if (cnt_reg == '0)
                begin
                    rsp_next.status = ST_FEW_FREE;
                    state_next = S_OUT;
                end
                else
                begin
                    we = 1'b1;
                    waddr = prev_reg;
                    wdata = END_MARK;
                    rsp_next.blocks_added = cnt_reg[9:0];
                    rsp_next.chain_length = len_reg + cnt_reg;
                    if (cnt_reg < CNT_W'(req_reg.amount))
                    begin
                        rsp_next.status = ST_FEW_FREE;
                    end
                    if (len_reg == '0)
                    begin
                        rsp_next.new_start = first_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_HOOK;
                    end
                end
            end
            S_HOOK:
            begin
                // Grow links the chain's tail to the fresh run; shrink puts
                // the end marker on the new last block.
                we = 1'b1;
                waddr = tail_reg;
                wdata = (req_reg.action == ACT_GROW) ? {1'b0, first_reg} : END_MARK;
                state_next = S_OUT;
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                // Step cnt_reg of the chain is block cur_reg; rdata is its link.
                // Only steps from the cut onwards are written, so earlier links
                // read as they were. A freed step whose link already reads as
                // free ends the pass: the rest only revisits freed blocks.
                if (cnt_reg + 1'b1 == cut)
                begin
                    tail_next = cur_reg;
                end
                if (cnt_reg >= cut)
                begin
                    we = 1'b1;
                    wdata = '0;
                end
                cnt_next = cnt_reg + 1'b1;
                cur_next = rdata[IDX_W-1:0];
                if (cnt_reg + 1'b1 == len_reg || (cnt_reg >= cut && rdata == '0))
                begin
                    state_next = (cut == '0) ? S_OUT : S_HOOK;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
